// File: src/idq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_pkg: shared types and constants for the indexed deque
// Field widths, command and status codes, controller state and control struct.
// ----------------------------------------------------------------------------
package idq_pkg;

  // default sizing
  localparam int DEPTH_DEF        = 1024;
  localparam int ELEMENT_BITS_DEF = 32;

  // fixed beat field widths
  localparam int CMD_W    = 3;
  localparam int POS_W    = 10;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_GET        = 3'd4,
    CMD_SET        = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic exec;   // execute the command beat on the input this cycle
  } ctrl_cmd_t;

endpackage

// File: src/idq_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_intf: valid/ready channels of the indexed deque
// Command channel and response channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface idq_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [idq_pkg::CMD_W-1:0]  command;
  logic [idq_pkg::POS_W-1:0]  position;
  logic [idq_pkg::VAL_W-1:0]  value;

  modport source (output valid, output command, output position, output value,
                  input ready);
  modport sink   (input valid, input command, input position, input value,
                  output ready);
endinterface

interface idq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [idq_pkg::STATUS_W-1:0]  status;
  logic [idq_pkg::VAL_W-1:0]     read_data;
  logic [idq_pkg::CNT_W-1:0]     count;

  modport source (output valid, output status, output read_data, output count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input count,
                  output ready);
endinterface

// File: src/idq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_ctrl: handshake controller
// Tracks whether a response beat is pending and issues execute strobes.
// ----------------------------------------------------------------------------
module idq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  output idq_pkg::ctrl_cmd_t cmd_o
);

  idq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      idq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = idq_pkg::ST_RESP;
      end
      idq_pkg::ST_RESP: begin
        if (out_ready_i && !in_valid_i) state_d = idq_pkg::ST_IDLE;
      end
      default: state_d = idq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      idq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      idq_pkg::ST_RESP: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;  // slot frees as the pending beat leaves
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.exec = in_valid_i && in_ready_o;
  end

endmodule

// File: src/idq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_dp: deque datapath
// Ring store, front pointer, element count and the registered response.
// ----------------------------------------------------------------------------
module idq_dp #(
  parameter int DEPTH        = idq_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = idq_pkg::ELEMENT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  idq_pkg::ctrl_cmd_t            cmd_i,
  input  logic [idq_pkg::CMD_W-1:0]     command_i,
  input  logic [idq_pkg::POS_W-1:0]     position_i,
  input  logic [idq_pkg::VAL_W-1:0]     value_i,
  output logic [idq_pkg::STATUS_W-1:0]  status_o,
  output logic [idq_pkg::VAL_W-1:0]     read_data_o,
  output logic [idq_pkg::CNT_W-1:0]     count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ELEMENT_BITS;

  logic [EW-1:0] mem [DEPTH];

  logic [AW-1:0]   front_q, front_d;
  logic [CW-1:0]   count_q, count_d;
  idq_pkg::status_e status_q, status_d;
  logic            rd_ok_q, rd_ok_d;
  logic [EW-1:0]   rd_data_q;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [EW-1:0]   wr_data;
  logic            is_empty, is_full, pos_ok;
  logic [AW-1:0]   front_dec, slot_back, slot_last, slot_pos;

  // (front + offset) mod DEPTH; the sum stays below twice DEPTH
  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                              input logic [CW-1:0] offs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(offs);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[AW-1:0];
  endfunction

  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(DEPTH));
  assign pos_ok    = (32'(position_i) < 32'(count_q));
  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign slot_back = ring_slot(front_q, count_q);
  assign slot_last = ring_slot(front_q, count_q - CW'(1));
  assign slot_pos  = ring_slot(front_q, CW'(position_i));
  assign wr_data   = EW'(value_i);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    status_d = idq_pkg::STS_OK;
    rd_ok_d  = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = slot_back;
    rd_addr  = front_q;
    unique case (idq_pkg::cmd_e'(command_i)) inside
      idq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_d = idq_pkg::STS_FULL;
        end else begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = front_dec;
        end
      end
      idq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_d = idq_pkg::STS_FULL;
        end else begin
          count_d = count_q + CW'(1);
          wr_en   = 1'b1;
          wr_addr = slot_back;
        end
      end
      idq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_d = idq_pkg::STS_EMPTY;
        end else begin
          front_d = ring_slot(front_q, CW'(1));
          count_d = count_q - CW'(1);
          rd_en   = 1'b1;
          rd_ok_d = 1'b1;
          rd_addr = front_q;
        end
      end
      idq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_d = idq_pkg::STS_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
          rd_en   = 1'b1;
          rd_ok_d = 1'b1;
          rd_addr = slot_last;
        end
      end
      idq_pkg::CMD_GET, idq_pkg::CMD_SET: begin
        if (is_empty) begin
          status_d = idq_pkg::STS_EMPTY;
        end else if (!pos_ok) begin
          status_d = idq_pkg::STS_RANGE;
        end else if (idq_pkg::cmd_e'(command_i) == idq_pkg::CMD_GET) begin
          rd_en   = 1'b1;
          rd_ok_d = 1'b1;
          rd_addr = slot_pos;
        end else begin
          wr_en   = 1'b1;
          wr_addr = slot_pos;
        end
      end
      default: ;  // unused codes leave state alone
    endcase
  end

  // ring store, registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[wr_addr] <= wr_data;
    if (cmd_i.exec && rd_en) rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      status_q <= idq_pkg::STS_OK;
      rd_ok_q  <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q  <= front_d;
      count_q  <= count_d;
      status_q <= status_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  assign status_o    = status_q;
  assign read_data_o = rd_ok_q ? idq_pkg::VAL_W'(rd_data_q) : '0;
  assign count_o     = idq_pkg::CNT_W'(count_q);

endmodule

// File: src/indexed_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_deque_top: bounded double-ended queue with indexed access
// Ring-store deque taking one command beat and returning one response beat.
// ----------------------------------------------------------------------------
// The response beat is valid in the cycle after its command beat is accepted.
// Throughput: one command per cycle while responses are taken at once; the
//   single response register holds the input off while its beat is stalled.
// The ring store is one memory with one write and one registered read port.
// Reset clears the front pointer, count and response flag at once; the ring
//   store is not cleared and no entry is read before it is written.
module indexed_deque_top #(
  parameter int DEPTH        = idq_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = idq_pkg::ELEMENT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  idq_cmd_if.sink  cmd_i,
  idq_rsp_if.source rsp_o
);

  // execute strobe from the controller to the datapath
  idq_pkg::ctrl_cmd_t ctrl_cmd;

  // Controller: one response slot; a new command enters when the slot is
  // empty or its beat is leaving in the same cycle.
  idq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (ctrl_cmd)
  );

  // Datapath: status decode, pointer/count update, store access and the
  // registered response fields.
  idq_dp #(
    .DEPTH        (DEPTH),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .command_i   (cmd_i.command),
    .position_i  (cmd_i.position),
    .value_i     (cmd_i.value),
    .status_o    (rsp_o.status),
    .read_data_o (rsp_o.read_data),
    .count_o     (rsp_o.count)
  );

endmodule

// File: src/idq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq_checker: port-level checks for the indexed deque
// Response consistency and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
module idq_checker #(
  parameter int DEPTH = idq_pkg::DEPTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [idq_pkg::STATUS_W-1:0]  status_i,
  input logic [idq_pkg::VAL_W-1:0]     read_data_i,
  input logic [idq_pkg::CNT_W-1:0]     count_i
);

  // failed commands return no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != idq_pkg::STS_OK |-> read_data_i == '0)
    else $error("idq: data on a failed command");

  // empty report means nothing stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == idq_pkg::STS_EMPTY |-> count_i == '0)
    else $error("idq: empty with nonzero count");

  // full report means count at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == idq_pkg::STS_FULL |-> count_i == idq_pkg::CNT_W'(DEPTH))
    else $error("idq: full below capacity");

  // stalled response beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(status_i) && $stable(read_data_i) && $stable(count_i))
    else $error("idq: stalled beat changed");

endmodule

bind indexed_deque_top idq_checker #(.DEPTH(DEPTH)) u_idq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .status_i    (rsp_o.status),
  .read_data_i (rsp_o.read_data),
  .count_i     (rsp_o.count)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the indexed deque
// Drives command beats (directed corner cases first, then random traffic that
// walks the ring from empty to full). A shadow deque predicts each
// response beat, and every beat is compared field by field. Both sides idle
// at random, and the response side is held off for a long stretch once.
// ----------------------------------------------------------------------------
import idq_pkg::*;

typedef struct packed {
  status_e           status;
  logic [VAL_W-1:0]  data;
  logic [CNT_W-1:0]  count;
} deque_rsp_t;

class deque_scoreboard;
  localparam int RING_DEPTH = DEPTH_DEF;
  localparam int MAX_PRINTS = 40;

  logic [VAL_W-1:0] ring [RING_DEPTH];
  logic [POS_W-1:0] head;
  logic [CNT_W-1:0] fill;
  deque_rsp_t       expected_q[$];
  int               errors;
  int               seen;

  function new();
    head   = '0;
    fill   = '0;
    errors = 0;
    seen   = 0;
  endfunction

  function int elements();
    return int'(fill);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  task report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    if (errors < MAX_PRINTS)
      $display("tb: mismatch at response %0d: %s got 0x%0h want 0x%0h",
               seen, what, got, want);
    errors++;
  endtask

  // Shadow deque: apply one accepted command, queue the response it yields.
  task note_command(cmd_e cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    deque_rsp_t       rsp;
    logic [POS_W-1:0] slot;
    rsp.status = STS_OK;
    rsp.data   = '0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill == CNT_W'(RING_DEPTH)) begin
          rsp.status = STS_FULL;
        end else if (cmd == CMD_PUSH_FRONT) begin
          head       = head - POS_W'(1);
          ring[head] = val;
          fill       = fill + CNT_W'(1);
        end else begin
          slot       = head + fill[POS_W-1:0];
          ring[slot] = val;
          fill       = fill + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == '0) begin
          rsp.status = STS_EMPTY;
        end else begin
          slot     = (cmd == CMD_POP_FRONT) ? head
                                            : head + fill[POS_W-1:0] - POS_W'(1);
          rsp.data = ring[slot];
          if (cmd == CMD_POP_FRONT) head = head + POS_W'(1);
          fill     = fill - CNT_W'(1);
        end
      end
      CMD_GET, CMD_SET: begin
        // empty wins over a bad index
        if (fill == '0) begin
          rsp.status = STS_EMPTY;
        end else if (CNT_W'(pos) >= fill) begin
          rsp.status = STS_RANGE;
        end else begin
          slot = head + pos;
          if (cmd == CMD_GET) rsp.data = ring[slot];
          else ring[slot] = val;
        end
      end
      default: ;
    endcase
    rsp.count = fill;
    expected_q.push_back(rsp);
  endtask

  task check_response(logic [STATUS_W-1:0] status, logic [VAL_W-1:0] data,
                      logic [CNT_W-1:0] count);
    deque_rsp_t want;
    seen++;
    if (expected_q.size() == 0) begin
      report("unexpected beat, status", VAL_W'(status), '0);
      return;
    end
    want = expected_q.pop_front();
    if (status !== want.status) report("status", VAL_W'(status), VAL_W'(want.status));
    if (data !== want.data)     report("read_data", data, want.data);
    if (count !== want.count)   report("count", VAL_W'(count), VAL_W'(want.count));
  endtask
endclass

module tb;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RSP_HOLD_CYCLES = 64;

  logic clk = 1'b0;
  logic rst_n;

  idq_cmd_if cmd_if ();
  idq_rsp_if rsp_if ();

  indexed_deque_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  always #5ns clk = ~clk;

  deque_scoreboard sb;
  bit steady;          // no idling on either side
  bit rsp_hold_req;    // ask the receiver for one long hold-off
  int calm_left;
  int idle_cycles;

  // ---- command side ----
  task automatic send_cmd(cmd_e cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= cmd;
    cmd_if.position <= pos;
    cmd_if.value    <= val;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_command(cmd, pos, val);
  endtask

  task automatic idle_cmd(int n);
    cmd_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (steady) return;
    if (calm_left > 0) begin
      calm_left--;
      return;
    end
    if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 80);
    else if ($urandom_range(0, 3) == 0) idle_cmd($urandom_range(1, 13));
  endtask

  task automatic drain_responses();
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random command; push_pct biases the fill level up or down.
  task automatic random_cmd(int push_pct);
    cmd_e             cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               n;
    n = sb.elements();
    case ($urandom_range(0, 9))
      0:       val = '0;
      1:       val = '1;
      default: val = $urandom;
    endcase
    if ($urandom_range(0, 99) < push_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else begin
      case ($urandom_range(0, 3))
        0:       cmd = CMD_POP_FRONT;
        1:       cmd = CMD_POP_BACK;
        2:       cmd = CMD_GET;
        default: cmd = CMD_SET;
      endcase
    end
    // mostly valid indexes, some just past the end or anywhere
    if (n > 0 && $urandom_range(0, 3) != 0) pos = POS_W'($urandom_range(0, n - 1));
    else if (n < DEPTH_DEF && $urandom_range(0, 1) == 0) pos = POS_W'(n);
    else pos = POS_W'($urandom);
    send_cmd(cmd, pos, val);
    sender_gap();
  endtask

  // ---- response side ----
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rsp_hold_req) begin
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk);
        rsp_hold_req = 1'b0;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.read_data, rsp_if.count);
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- stimulus ----
  initial begin
    sb           = new();
    steady       = 1'b0;
    rsp_hold_req = 1'b0;
    calm_left    = 0;
    rst_n           <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= CMD_PUSH_FRONT;
    cmd_if.position <= '0;
    cmd_if.value    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: empty before index, range edges, both ends
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_GET, '1, '0);
    send_cmd(CMD_SET, '0, 32'h1234_5678);
    send_cmd(CMD_PUSH_BACK, '0, '1);
    send_cmd(CMD_PUSH_FRONT, '1, '0);
    send_cmd(CMD_PUSH_FRONT, '0, 32'h1234_5678);
    send_cmd(CMD_GET, 10'd0, '0);
    send_cmd(CMD_GET, 10'd2, '0);
    send_cmd(CMD_GET, 10'd3, '0);
    send_cmd(CMD_GET, '1, '0);
    send_cmd(CMD_SET, 10'd1, 32'hA5A5_A5A5);
    send_cmd(CMD_SET, 10'd3, 32'h5A5A_5A5A);
    send_cmd(CMD_GET, 10'd1, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_POP_FRONT, '0, '0);
    idle_cmd(3);
    send_cmd(CMD_POP_FRONT, '0, '0);
    send_cmd(CMD_POP_BACK, '0, '0);
    send_cmd(CMD_PUSH_BACK, '0, 32'h5A5A_5A5A);
    send_cmd(CMD_GET, 10'd0, '0);

    // mixed traffic at low fill; receiver stalls long midway
    for (int i = 0; i < 250; i++) begin
      if (i == 120) rsp_hold_req = 1'b1;
      random_cmd(45);
    end

    // sender pause until everything is back
    drain_responses();
    idle_cmd(4);

    // fill the ring to the top
    while (sb.elements() < DEPTH_DEF) random_cmd(85);
    send_cmd(CMD_PUSH_FRONT, '0, 32'hDEAD_BEEF);
    send_cmd(CMD_PUSH_BACK, '0, 32'hDEAD_BEEF);
    send_cmd(CMD_SET, '1, '1);
    send_cmd(CMD_GET, '1, '0);
    send_cmd(CMD_GET, '0, '0);
    for (int i = 0; i < 40; i++) random_cmd(50);

    // closing stretch with no idling on either side
    steady = 1'b1;
    for (int i = 0; i < 100; i++) random_cmd(30);

    drain_responses();
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
